### rtl/pnguf_pkg.sv
// Shared types, constants and register indexes of the PNG scanline unfilter.
`timescale 1ns / 1ps
`default_nettype none

package pnguf_pkg;

  localparam int MAX_LINE_BYTES  = 8192;
  localparam int MAX_PIXEL_BYTES = 8;
  localparam int COL_W           = $clog2(MAX_LINE_BYTES);
  localparam int PIX_W           = $clog2(MAX_PIXEL_BYTES);

  typedef logic [COL_W-1:0] col_t;
  typedef logic [PIX_W-1:0] pix_idx_t;

  // Filter type codes of PNG filter method 0.
  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_BYTES_PER_LINE  = 2'd0;
  localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [1:0] REG_ROWS_PER_IMAGE  = 2'd2;

  // One data byte or error marker on its way into the reconstruction stage.
  typedef struct packed {
    logic       valid;
    logic       err;
    logic [7:0] data;
    logic [2:0] kind;
    col_t       col;
    pix_idx_t   bpp_idx;
    logic       first_row;
    logic       left_ok;
    logic       eor;
    logic       eoi;
  } item_t;

  typedef struct packed {
    logic [7:0] recon_byte;
    logic       end_of_row;
    logic       end_of_image;
    logic       bad_filter;
  } result_t;

  typedef struct packed {
    logic       en;
    col_t       addr;
    logic [7:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

### rtl/pnguf_line_ram.sv
// Single-port-write, registered-read memory that holds the previous row.
`timescale 1ns / 1ps
`default_nettype none

module pnguf_line_ram (
  input  wire logic              clk,
  input  wire pnguf_pkg::ram_wr_t wr,
  input  wire logic              rd_en,
  input  wire pnguf_pkg::col_t   rd_addr,
  output logic [7:0]             rd_data
);
  import pnguf_pkg::*;

  logic [7:0] mem [MAX_LINE_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/pnguf_seq.sv
// Configuration registers and the row/column sequencer in front of the line memory.
`timescale 1ns / 1ps
`default_nettype none

module pnguf_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             accept,
  input  wire logic [7:0]       filtered_byte,
  output pnguf_pkg::item_t      item
);
  import pnguf_pkg::*;

  logic [13:0] bpl_r;
  logic [3:0]  bpp_r;
  logic [15:0] rows_r;
  logic        halted_r, halted_nxt;
  logic        expect_r, expect_nxt;
  logic [2:0]  kind_r, kind_nxt;
  col_t        col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic        first_r, first_nxt;

  logic [13:0] bpl_eff;
  logic [3:0]  bpp_eff;
  logic [15:0] rows_eff;
  logic        row_end;
  logic        img_end;
  logic        bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r  <= 14'd1;
      bpp_r  <= 4'd1;
      rows_r <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BYTES_PER_LINE:  bpl_r  <= cfg_data[13:0];
        REG_BYTES_PER_PIXEL: bpp_r  <= cfg_data[3:0];
        REG_ROWS_PER_IMAGE:  rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bpl_r == 14'd0) begin
      bpl_eff = 14'd1;
    end else if (bpl_r > 14'(MAX_LINE_BYTES)) begin
      bpl_eff = 14'(MAX_LINE_BYTES);
    end else begin
      bpl_eff = bpl_r;
    end
    if (bpp_r == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (bpp_r > 4'(MAX_PIXEL_BYTES)) begin
      bpp_eff = 4'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_r;
    end
    rows_eff = (rows_r == 16'd0) ? 16'd1 : rows_r;
  end

  assign row_end = ({1'b0, col_r} + 14'd1) >= bpl_eff;
  assign img_end = row_end && (({1'b0, row_r} + 17'd1) >= {1'b0, rows_eff});
  assign bad     = filtered_byte > {5'd0, FLT_PAETH};

  always_comb begin
    item.valid     = accept && !halted_r && (!expect_r || bad);
    item.err       = expect_r;
    item.data      = filtered_byte;
    item.kind      = kind_r;
    item.col       = col_r;
    item.bpp_idx   = PIX_W'(bpp_eff - 4'd1);
    item.first_row = first_r;
    item.left_ok   = col_r >= COL_W'(bpp_eff);
    item.eor       = row_end;
    item.eoi       = img_end;
  end

  always_comb begin
    halted_nxt = halted_r;
    expect_nxt = expect_r;
    kind_nxt   = kind_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    first_nxt  = first_r;
    if (accept && !halted_r) begin
      if (expect_r) begin
        if (bad) begin
          halted_nxt = 1'b1;
        end else begin
          kind_nxt   = filtered_byte[2:0];
          expect_nxt = 1'b0;
          col_nxt    = '0;
        end
      end else if (row_end) begin
        expect_nxt = 1'b1;
        row_nxt    = img_end ? 16'd0 : row_r + 16'd1;
        first_nxt  = img_end;
      end else begin
        col_nxt = col_r + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
      expect_r <= 1'b1;
      kind_r   <= FLT_NONE;
      col_r    <= '0;
      row_r    <= 16'd0;
      first_r  <= 1'b1;
    end else begin
      halted_r <= halted_nxt;
      expect_r <= expect_nxt;
      kind_r   <= kind_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/pnguf_recon.sv
// Reconstruction stage: neighbour windows, filter arithmetic and line memory write-back.
`timescale 1ns / 1ps
`default_nettype none

module pnguf_recon (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pnguf_pkg::item_t  ld,
  input  wire logic              adv,
  input  wire logic [7:0]        above,
  output logic                   busy,
  output pnguf_pkg::result_t     res,
  output pnguf_pkg::ram_wr_t     wr
);
  import pnguf_pkg::*;

  item_t      s1_r;
  logic [7:0] left_r  [MAX_PIXEL_BYTES];
  logic [7:0] uleft_r [MAX_PIXEL_BYTES];

  logic [7:0]        a, b, c, pred, r;
  logic [8:0]        sum_ab;
  logic signed [9:0] d_pa, d_pb, d_pc;
  logic [9:0]        pa, pb, pc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (ld.valid) begin
      s1_r <= ld;
    end else if (adv) begin
      s1_r.valid <= 1'b0;
    end
  end

  assign busy = s1_r.valid;

  always_comb begin
    a = s1_r.left_ok ? left_r[s1_r.bpp_idx] : 8'd0;
    c = (s1_r.left_ok && !s1_r.first_row) ? uleft_r[s1_r.bpp_idx] : 8'd0;
    b = s1_r.first_row ? 8'd0 : above;
  end

  // Paeth predictor on signed differences; ties prefer a, then b.
  always_comb begin
    sum_ab = {1'b0, a} + {1'b0, b};
    d_pa = $signed({2'b00, b}) - $signed({2'b00, c});
    d_pb = $signed({2'b00, a}) - $signed({2'b00, c});
    d_pc = $signed({1'b0, sum_ab}) - $signed({1'b0, c, 1'b0});
    pa = (d_pa < 0) ? 10'(-d_pa) : 10'(d_pa);
    pb = (d_pb < 0) ? 10'(-d_pb) : 10'(d_pb);
    pc = (d_pc < 0) ? 10'(-d_pc) : 10'(d_pc);
  end

  always_comb begin
    case (s1_r.kind)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = sum_ab[8:1];
      FLT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:   pred = 8'd0;
    endcase
    r = s1_r.data + pred;
  end

  always_comb begin
    if (s1_r.err) begin
      res.recon_byte   = 8'd0;
      res.end_of_row   = 1'b0;
      res.end_of_image = 1'b0;
      res.bad_filter   = 1'b1;
    end else begin
      res.recon_byte   = r;
      res.end_of_row   = s1_r.eor;
      res.end_of_image = s1_r.eoi;
      res.bad_filter   = 1'b0;
    end
    wr.en   = adv && !s1_r.err;
    wr.addr = s1_r.col;
    wr.data = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i]  <= 8'd0;
        uleft_r[i] <= 8'd0;
      end
    end else if (adv && !s1_r.err) begin
      left_r[0]  <= r;
      uleft_r[0] <= b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_r[i]  <= left_r[i-1];
        uleft_r[i] <= uleft_r[i-1];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/png_scanline_unfilter_core.sv
// PNG scanline unfilter: undoes filter method 0 on an inflated image stream.
// Input channel: one stream byte per transfer on in_filtered_byte. The first
// byte of each row is the filter type and gives no result; every following
// byte gives one reconstructed byte on the output channel, with end_of_row
// and end_of_image flags. A filter type above four gives one result with
// out_bad_filter set, after which input is taken and dropped until reset.
// Configuration: cfg_index selects bytes_per_line (0), bytes_per_pixel (1) or
// rows_per_image (2); cfg_ready is always high. Write only while idle.
// Throughput is one byte per clock while out_stall is low. An input transfer
// passes the synchronous read of the row-above memory, then the
// reconstruction and the output register before its result is offered.
// While out_stall is high the result is held, the reconstruction stage fills
// and then in_stall rises; the block takes input again as soon as the
// output register moves. Reset clears the position, row count, windows and
// error state; the row-above memory is not cleared, its data is ignored on the
// first row and used only after the previous row has written the same column.
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_filtered_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_recon_byte,
  output logic             out_end_of_row,
  output logic             out_end_of_image,
  output logic             out_bad_filter,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import pnguf_pkg::*;

  item_t      item;
  result_t    res;
  ram_wr_t    wr;
  logic       busy;
  logic       adv;
  logic       accept;
  logic [7:0] above;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;

  assign cfg_ready = 1'b1;
  assign adv       = busy && (!out_valid_r || !out_stall);
  assign in_stall  = busy && !adv;
  assign accept    = in_valid && !in_stall;

  pnguf_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .filtered_byte (in_filtered_byte),
    .item          (item)
  );

  pnguf_line_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (item.valid && !item.err),
    .rd_addr (item.col),
    .rd_data (above)
  );

  pnguf_recon u_recon (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (item),
    .adv   (adv),
    .above (above),
    .busy  (busy),
    .res   (res),
    .wr    (wr)
  );

  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_recon_byte   = out_r.recon_byte;
  assign out_end_of_row   = out_r.end_of_row;
  assign out_end_of_image = out_r.end_of_image;
  assign out_bad_filter   = out_r.bad_filter;

endmodule

`default_nettype wire
